/* src/indexed_insert_delete_queue_macros.svh */
// ----------------------------------------------------------------------------
// indexed_insert_delete_queue_macros
// assertion macros shared by the queue rtl
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_QUEUE_MACROS_SVH
`define INDEXED_INSERT_DELETE_QUEUE_MACROS_SVH

// condition must hold at every edge out of reset
`define IIDQ_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define IIDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/iidq_pkg.sv */
// ----------------------------------------------------------------------------
// iidq_pkg
// types and constants of the indexed insert/delete queue
// ----------------------------------------------------------------------------
package iidq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DEPTH_MAX = 256;
  localparam int WORD_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 5;
  localparam int COUNT_W   = 5;
  localparam int STATUS_W  = 2;
  // wide enough for any position or occupancy up to the largest depth
  localparam int IDX_W     = $clog2(DEPTH_MAX + 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_INS = 2'd2,
    OP_DEL = 2'd3
  } iidq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_POS   = 2'd3
  } iidq_status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
  } iidq_ctl_t;

endpackage

/* src/iidq_cell.sv */
// ----------------------------------------------------------------------------
// iidq_cell
// one storage slot of the queue, shifts toward or away from the head
// ----------------------------------------------------------------------------
module iidq_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  iidq_pkg::iidq_ctl_t            ctl,
  input  logic [iidq_pkg::WORD_W-1:0]    new_word,
  input  logic [iidq_pkg::WORD_W-1:0]    left_word,
  input  logic [iidq_pkg::WORD_W-1:0]    right_word,
  output logic [iidq_pkg::WORD_W-1:0]    word
);
  import iidq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (MY_IDX == ctl.pos) begin
        word_nxt = new_word;
      end else if (MY_IDX > ctl.pos) begin
        word_nxt = left_word;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= ctl.pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

/* src/indexed_insert_delete_queue.sv */
// result: registered and shown on the out_ port in the cycle after acceptance
// throughput: one request per cycle while in_stall is low; every cell of the
//   chain shifts in the same cycle, so any insert or delete is one shift
// reset: rst_n low clears the occupancy and the result valid; the cells
//   hold no reset and are only read below the occupancy
// ----------------------------------------------------------------------------
// indexed_insert_delete_queue
// ordered queue with enqueue, dequeue, insert and delete at a position
// ----------------------------------------------------------------------------
module indexed_insert_delete_queue #(
  parameter int DEPTH = iidq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [iidq_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [iidq_pkg::WORD_W-1:0]  in_word_in,
  input  logic [iidq_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [iidq_pkg::WORD_W-1:0]  out_word_out,
  output logic [iidq_pkg::STATUS_W-1:0]       out_status,
  output logic [iidq_pkg::COUNT_W-1:0]        out_count
);
  import iidq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  occ_r;
  logic [CNT_W-1:0]  occ_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic              accept;
  logic              do_ins;
  logic              do_del;
  logic [IDX_W-1:0]  op_pos;
  logic [IDX_W-1:0]  pos_x;
  logic [IDX_W-1:0]  occ_x;
  logic              full;
  logic              empty;
  iidq_status_t      status;
  logic [WORD_W-1:0] removed;
  iidq_ctl_t         ctl;
  logic [WORD_W-1:0] cell_word [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pos_x    = IDX_W'(in_position);
  assign occ_x    = IDX_W'(occ_r);
  assign full     = (occ_x == IDX_W'(DEPTH));
  assign empty    = (occ_r == '0);

  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    op_pos  = pos_x;
    status  = ST_OK;
    removed = '0;
    unique case (iidq_op_t'(in_func))
      OP_ENQ: begin
        op_pos = occ_x;
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DEQ: begin
        op_pos = '0;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_del  = 1'b1;
          removed = cell_word[0];
        end
      end
      OP_INS: begin
        if (pos_x > occ_x) begin
          status = ST_POS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DEL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_x >= occ_x) begin
          status = ST_POS;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    ctl.ins = accept && do_ins;
    ctl.del = accept && do_del;
    ctl.pos = op_pos;
    occ_nxt = occ_r;
    if (ctl.ins) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (ctl.del) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  // chain of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_head
      assign left_w = in_word_in;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    iidq_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_word   (in_word_in),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r   <= removed;
      out_status_r <= status;
      out_count_r  <= COUNT_W'(occ_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

`include "indexed_insert_delete_queue_macros.svh"

  `IIDQ_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_x <= IDX_W'(DEPTH), "occupancy above depth")
  `IIDQ_ASSERT_NEXT(a_ins_grows, clk, rst_n, ctl.ins, occ_r == $past(occ_r) + CNT_W'(1), "insert did not grow occupancy")
  `IIDQ_ASSERT_NEXT(a_err_keeps, clk, rst_n, accept && status != ST_OK, occ_r == $past(occ_r) && out_word_out == '0, "failed request changed state")
  `IIDQ_ASSERT_ALWAYS(a_word_ok, clk, rst_n, !out_valid_r || out_word_r == '0 || out_status_r == ST_OK, "word returned with error status")

endmodule
